// ===== rtl/core/ffha_pkg.sv =====
`default_nettype none
package ffha_pkg;

  // arena geometry
  localparam int unsigned ARENA_BYTES  = 4096;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned ALIGN_BYTES  = 8;
  localparam int unsigned IDX_W        = 9;   // one header slot per 8-byte granule
  localparam int unsigned OFF_W        = 12;  // byte offset inside the arena
  localparam int unsigned SIZE_W       = 13;  // payload size in bytes

  // request types
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_IGNORE = 2'd1;
  localparam logic [1:0] ST_NOFIT  = 2'd2;
  localparam logic [1:0] ST_DOUBLE = 2'd3;

  // chunk header as kept in the header memory
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              is_free;
    logic [IDX_W-1:0]  next;
    logic              has_next;
  } hdr_t;

  // header memory write port
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    hdr_t             data;
  } hdr_wr_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] alloc_size;
    logic [11:0] block_address;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] result_address;
    logic [12:0] avail_bytes;
  } out_rsp_t;

  // slot zero after reset: one free chunk spanning the whole arena
  localparam hdr_t HDR_RESET = '{size: SIZE_W'(ARENA_BYTES - HEADER_BYTES), is_free: 1'b1,
                                 next: '0, has_next: 1'b0};

endpackage
`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator.sv =====
`default_nettype none
// First-fit allocator over a 4096-byte arena with 16-byte chunk headers kept in
// a single-port-write header memory. A request is taken when start is high and
// busy is low; its one result appears on out_data for exactly one cycle with
// out_valid high and must be captured then, as the block cannot be stalled.
// An allocate walks the free list, then splits or unlinks and marks the chunk;
// a free walks the chunk chain from offset 0 to the block, then the free list.
// The bound is the header memory walk, one chunk per cycle through its registered
// read. Zero-size allocates, empty-list allocates and null frees skip the walk.
module first_fit_heap_allocator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire ffha_pkg::in_req_t  in_data,
  output logic                    out_valid,
  output ffha_pkg::out_rsp_t      out_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_AWALK  = 4'd1;
  localparam logic [3:0] S_AW1    = 4'd2;
  localparam logic [3:0] S_AW2    = 4'd3;
  localparam logic [3:0] S_AW3    = 4'd4;
  localparam logic [3:0] S_FWALK  = 4'd5;
  localparam logic [3:0] S_FLIST  = 4'd6;
  localparam logic [3:0] S_FMERGE = 4'd7;
  localparam logic [3:0] S_FRDC   = 4'd8;
  localparam logic [3:0] S_FWB    = 4'd9;

  localparam logic [12:0] HDR13   = 13'(ffha_pkg::HEADER_BYTES);
  localparam logic [12:0] ARENA13 = 13'(ffha_pkg::ARENA_BYTES);

  logic [3:0]        state_r, state_nxt;
  logic [16:0]       sz_r, sz_nxt;
  logic [8:0]        cur_r, cur_nxt, prev_r, prev_nxt, m_idx_r, m_idx_nxt;
  logic [8:0]        head_r, head_nxt;
  logic              head_v_r, head_v_nxt;
  ffha_pkg::hdr_t    cur_d_r, cur_d_nxt, prev_d_r, prev_d_nxt;
  ffha_pkg::hdr_t    blk_d_r, blk_d_nxt, m_d_r, m_d_nxt;
  logic              has_prev_r, has_prev_nxt, valid_r, valid_nxt;
  logic              coal_r, coal_nxt, split_r, split_nxt;
  logic [11:0]       blk_r, blk_nxt;
  logic [12:0]       walk_r, walk_nxt, rest_r, rest_nxt;
  logic [12:0]       avail_r, avail_nxt;
  logic              out_valid_r, out_valid_nxt;
  ffha_pkg::out_rsp_t out_r, out_nxt;

  logic [8:0]        rd_idx;
  ffha_pkg::hdr_wr_t wr;
  ffha_pkg::hdr_t    rdata;

  ffha_hdr_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (rd_idx),
    .wr      (wr),
    .rd_data (rdata)
  );

  // scratch values
  logic        fin;
  logic [1:0]  fin_st;
  logic [11:0] fin_addr;
  logic [16:0] sz_rnd;
  logic [12:0] wn, nf_off, prev_end, m_end, used;
  logic [13:0] avail_sum;
  ffha_pkg::hdr_t d;

  always_comb begin
    state_nxt     = state_r;
    sz_nxt        = sz_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    m_idx_nxt     = m_idx_r;
    head_nxt      = head_r;
    head_v_nxt    = head_v_r;
    cur_d_nxt     = cur_d_r;
    prev_d_nxt    = prev_d_r;
    blk_d_nxt     = blk_d_r;
    m_d_nxt       = m_d_r;
    has_prev_nxt  = has_prev_r;
    valid_nxt     = valid_r;
    coal_nxt      = coal_r;
    split_nxt     = split_r;
    blk_nxt       = blk_r;
    walk_nxt      = walk_r;
    rest_nxt      = rest_r;
    avail_nxt     = avail_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_idx        = '0;
    wr            = '0;
    fin           = 1'b0;
    fin_st        = ffha_pkg::ST_OK;
    fin_addr      = '0;
    d             = m_d_r;

    sz_rnd    = ({1'b0, in_data.alloc_size} + 17'd7) & ~17'd7;
    wn        = walk_r + HDR13 + rdata.size;
    nf_off    = {1'b0, cur_r, 3'b000} + HDR13 + sz_r[12:0];
    prev_end  = {1'b0, prev_r, 3'b000} + HDR13 + prev_d_r.size;
    m_end     = {1'b0, m_idx_r, 3'b000} + HDR13 + m_d_r.size;
    avail_sum = {1'b0, avail_r} + {1'b0, rdata.size} + {1'b0, HDR13};
    used      = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_data.req_type == ffha_pkg::REQ_ALLOC) begin
            sz_nxt = sz_rnd;
            if (in_data.alloc_size == '0) begin
              fin = 1'b1; fin_st = ffha_pkg::ST_IGNORE;
            end else if (!head_v_r) begin
              fin = 1'b1; fin_st = ffha_pkg::ST_NOFIT;
            end else begin
              rd_idx       = head_r;
              cur_nxt      = head_r;
              has_prev_nxt = 1'b0;
              state_nxt    = S_AWALK;
            end
          end else begin
            if (in_data.block_address < 12'(ffha_pkg::HEADER_BYTES)) begin
              fin = 1'b1; fin_st = ffha_pkg::ST_IGNORE;
            end else begin
              blk_nxt   = in_data.block_address - 12'(ffha_pkg::HEADER_BYTES);
              walk_nxt  = '0;
              rd_idx    = '0;
              state_nxt = S_FWALK;
            end
          end
        end
      end

      // allocate: visit one free chunk per cycle
      S_AWALK: begin
        if ({4'b0, rdata.size} >= sz_r) begin
          cur_d_nxt = rdata;
          rest_nxt  = rdata.size - sz_r[12:0];
          split_nxt = (rdata.size - sz_r[12:0]) > HDR13;
          state_nxt = S_AW1;
        end else begin
          prev_nxt     = cur_r;
          prev_d_nxt   = rdata;
          has_prev_nxt = 1'b1;
          if (rdata.has_next) begin
            cur_nxt = rdata.next;
            rd_idx  = rdata.next;
          end else begin
            fin = 1'b1; fin_st = ffha_pkg::ST_NOFIT;
          end
        end
      end

      // split off the tail, or unlink the whole chunk
      S_AW1: begin
        if (split_r) begin
          wr.en   = 1'b1;
          wr.idx  = nf_off[11:3];
          wr.data = '{size: rest_r - HDR13, is_free: 1'b1,
                      next: cur_d_r.next, has_next: cur_d_r.has_next};
        end else if (has_prev_r) begin
          wr.en            = 1'b1;
          wr.idx           = prev_r;
          wr.data          = prev_d_r;
          wr.data.next     = cur_d_r.next;
          wr.data.has_next = cur_d_r.has_next;
        end else begin
          head_nxt   = cur_d_r.next;
          head_v_nxt = cur_d_r.has_next;
        end
        state_nxt = S_AW2;
      end

      // link the split tail in place of the chosen chunk
      S_AW2: begin
        if (split_r) begin
          if (has_prev_r) begin
            wr.en            = 1'b1;
            wr.idx           = prev_r;
            wr.data          = prev_d_r;
            wr.data.next     = nf_off[11:3];
            wr.data.has_next = 1'b1;
          end else begin
            head_nxt   = nf_off[11:3];
            head_v_nxt = 1'b1;
          end
        end
        state_nxt = S_AW3;
      end

      // mark the chunk used and charge it
      S_AW3: begin
        d = cur_d_r;
        if (split_r) begin
          d.size = sz_r[12:0];
        end
        d.is_free = 1'b0;
        wr.en     = 1'b1;
        wr.idx    = cur_r;
        wr.data   = d;
        used      = d.size + HDR13;
        avail_nxt = (avail_r > used) ? avail_r - used : '0;
        fin       = 1'b1;
        fin_st    = ffha_pkg::ST_OK;
        fin_addr  = {cur_r, 3'b000} + 12'(ffha_pkg::HEADER_BYTES);
      end

      // free: walk the chunk chain from offset zero to find the block
      S_FWALK: begin
        if (walk_r == {1'b0, blk_r}) begin
          if (rdata.is_free) begin
            fin = 1'b1; fin_st = ffha_pkg::ST_DOUBLE;
          end else begin
            blk_d_nxt    = rdata;
            avail_nxt    = (avail_sum > {1'b0, ARENA13}) ? ARENA13 : avail_sum[12:0];
            has_prev_nxt = 1'b0;
            cur_nxt      = head_r;
            valid_nxt    = head_v_r;
            if (head_v_r && {head_r, 3'b000} < blk_r) begin
              rd_idx    = head_r;
              state_nxt = S_FLIST;
            end else begin
              state_nxt = S_FMERGE;
            end
          end
        end else if (wn > {1'b0, blk_r}) begin
          fin = 1'b1; fin_st = ffha_pkg::ST_IGNORE;
        end else begin
          walk_nxt = wn;
          rd_idx   = wn[11:3];
        end
      end

      // find the free neighbors around the block
      S_FLIST: begin
        prev_nxt     = cur_r;
        prev_d_nxt   = rdata;
        has_prev_nxt = 1'b1;
        cur_nxt      = rdata.next;
        valid_nxt    = rdata.has_next;
        if (rdata.has_next && {rdata.next, 3'b000} < blk_r) begin
          rd_idx = rdata.next;
        end else begin
          state_nxt = S_FMERGE;
        end
      end

      // merge into the previous chunk, or link in after it
      S_FMERGE: begin
        if (has_prev_r && prev_end == {1'b0, blk_r}) begin
          m_idx_nxt      = prev_r;
          m_d_nxt        = prev_d_r;
          m_d_nxt.size   = prev_d_r.size + HDR13 + blk_d_r.size;
        end else begin
          m_idx_nxt = blk_r[11:3];
          m_d_nxt   = '{size: blk_d_r.size, is_free: 1'b1, next: cur_r, has_next: valid_r};
          if (has_prev_r) begin
            wr.en            = 1'b1;
            wr.idx           = prev_r;
            wr.data          = prev_d_r;
            wr.data.next     = blk_r[11:3];
            wr.data.has_next = 1'b1;
          end else begin
            head_nxt   = blk_r[11:3];
            head_v_nxt = 1'b1;
          end
        end
        state_nxt = S_FRDC;
      end

      // fetch the following free chunk and note whether it touches
      S_FRDC: begin
        rd_idx    = cur_r;
        coal_nxt  = valid_r && (m_end == {1'b0, cur_r, 3'b000});
        state_nxt = S_FWB;
      end

      S_FWB: begin
        d = m_d_r;
        if (coal_r) begin
          d.size     = m_d_r.size + HDR13 + rdata.size;
          d.next     = rdata.next;
          d.has_next = rdata.has_next;
        end
        wr.en   = 1'b1;
        wr.idx  = m_idx_r;
        wr.data = d;
        fin     = 1'b1;
        fin_st  = ffha_pkg::ST_OK;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // result transfer
    if (fin) begin
      state_nxt             = S_IDLE;
      out_valid_nxt         = 1'b1;
      out_nxt.status        = fin_st;
      out_nxt.result_address = fin_addr;
      out_nxt.avail_bytes   = avail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      head_v_r    <= 1'b1;
      avail_r     <= ARENA13;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      head_v_r    <= head_v_nxt;
      avail_r     <= avail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sz_r       <= sz_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    m_idx_r    <= m_idx_nxt;
    cur_d_r    <= cur_d_nxt;
    prev_d_r   <= prev_d_nxt;
    blk_d_r    <= blk_d_nxt;
    m_d_r      <= m_d_nxt;
    has_prev_r <= has_prev_nxt;
    valid_r    <= valid_nxt;
    coal_r     <= coal_nxt;
    split_r    <= split_nxt;
    blk_r      <= blk_nxt;
    walk_r     <= walk_nxt;
    rest_r     <= rest_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !(in_data.req_type == ffha_pkg::REQ_ALLOC && !head_v_r) &&
     in_data.alloc_size != '0 && in_data.block_address >= 12'd16) |=> busy)
    else $error("accepted request did not start a walk");
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still working");
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ffha_pkg::ST_OK) |-> out_data.result_address == '0)
    else $error("address on failed request");
  a_avail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    avail_r <= ARENA13)
    else $error("available bytes above arena size");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/ffha_hdr_mem.sv =====
`default_nettype none
module ffha_hdr_mem (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [ffha_pkg::IDX_W-1:0]  rd_idx,
  input  wire ffha_pkg::hdr_wr_t           wr,
  output ffha_pkg::hdr_t                   rd_data
);

  ffha_pkg::hdr_t mem [0:(1 << ffha_pkg::IDX_W)-1];
  ffha_pkg::hdr_t mem_q;
  logic           slot0_written_r;
  logic           rd_zero_r;

  // storage: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
    mem_q <= mem[rd_idx];
  end

  // slot zero reads as the initial chunk until it is first written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot0_written_r <= 1'b0;
      rd_zero_r       <= 1'b0;
    end else begin
      if (wr.en && wr.idx == '0) begin
        slot0_written_r <= 1'b1;
      end
      rd_zero_r <= (rd_idx == '0) && !slot0_written_r;
    end
  end

  assign rd_data = rd_zero_r ? ffha_pkg::HDR_RESET : mem_q;

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
module tb_top;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int RANDOM_ITEMS = 450;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  ffha_pkg::in_req_t in_data;
  logic out_valid;
  ffha_pkg::out_rsp_t out_data;

  first_fit_heap_allocator dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow heap: one header per byte offset, as the allocator sees it
  int chunk_size[ffha_pkg::ARENA_BYTES];
  bit chunk_free[ffha_pkg::ARENA_BYTES];
  int chunk_next[ffha_pkg::ARENA_BYTES];
  bit chunk_has_next[ffha_pkg::ARENA_BYTES];
  int free_head_off;
  bit free_list_valid;
  int avail_total;

  ffha_pkg::out_rsp_t pending_rsp[$];
  int live_blocks[$];
  int released_blocks[$];
  int error_count;
  int cycle_count;
  int burst_left;

  function automatic void heap_reset();
    for (int i = 0; i < ffha_pkg::ARENA_BYTES; i++) begin
      chunk_size[i] = 0;
      chunk_free[i] = 1'b0;
      chunk_next[i] = 0;
      chunk_has_next[i] = 1'b0;
    end
    chunk_size[0] = ffha_pkg::ARENA_BYTES - ffha_pkg::HEADER_BYTES;
    chunk_free[0] = 1'b1;
    free_head_off = 0;
    free_list_valid = 1'b1;
    avail_total = ffha_pkg::ARENA_BYTES;
  endfunction

  // relink helper: point prev (or the list head) at target
  function automatic void set_link(bit has_prev, int prev, bit tvalid, int target);
    if (has_prev) begin
      chunk_next[prev] = target;
      chunk_has_next[prev] = tvalid;
    end else begin
      free_head_off = target;
      free_list_valid = tvalid;
    end
  endfunction

  // first-fit walk with split; returns status, payload offset through addr
  function automatic logic [1:0] heap_allocate(int req_size, output int addr);
    int cur;
    int prev;
    int rest;
    int nf;
    int used;
    bit valid;
    bit has_prev;
    cur = free_head_off;
    prev = 0;
    valid = free_list_valid;
    has_prev = 1'b0;
    addr = 0;
    if (req_size == 0) return ffha_pkg::ST_IGNORE;
    if (req_size % ffha_pkg::ALIGN_BYTES != 0)
      req_size += ffha_pkg::ALIGN_BYTES - (req_size % ffha_pkg::ALIGN_BYTES);
    while (valid && cur < ffha_pkg::ARENA_BYTES) begin
      if (chunk_size[cur] >= req_size) begin
        rest = chunk_size[cur] - req_size;
        if (rest > ffha_pkg::HEADER_BYTES) begin
          nf = cur + ffha_pkg::HEADER_BYTES + req_size;
          if (nf < ffha_pkg::ARENA_BYTES) begin
            chunk_size[nf] = rest - ffha_pkg::HEADER_BYTES;
            chunk_free[nf] = 1'b1;
            chunk_next[nf] = chunk_next[cur];
            chunk_has_next[nf] = chunk_has_next[cur];
            set_link(has_prev, prev, 1'b1, nf);
          end
          chunk_size[cur] = req_size;
        end else begin
          set_link(has_prev, prev, chunk_has_next[cur], chunk_next[cur]);
        end
        chunk_free[cur] = 1'b0;
        used = chunk_size[cur] + ffha_pkg::HEADER_BYTES;
        avail_total = (avail_total > used) ? avail_total - used : 0;
        addr = cur + ffha_pkg::HEADER_BYTES;
        return ffha_pkg::ST_OK;
      end
      prev = cur;
      has_prev = 1'b1;
      valid = chunk_has_next[cur];
      cur = chunk_next[cur];
    end
    return ffha_pkg::ST_NOFIT;
  endfunction

  // release with address-ordered insert and merge on both sides
  function automatic logic [1:0] heap_release(int addr);
    int blk;
    int cur;
    int prev;
    int walk;
    bit valid;
    bit has_prev;
    bit found;
    prev = 0;
    walk = 0;
    has_prev = 1'b0;
    found = 1'b0;
    if (addr == 0 || addr < ffha_pkg::HEADER_BYTES) return ffha_pkg::ST_IGNORE;
    blk = addr - ffha_pkg::HEADER_BYTES;
    while (walk < ffha_pkg::ARENA_BYTES) begin
      if (walk == blk) begin
        found = 1'b1;
        break;
      end
      if (walk > blk) break;
      walk += ffha_pkg::HEADER_BYTES + chunk_size[walk];
    end
    if (!found) return ffha_pkg::ST_IGNORE;
    if (chunk_free[blk]) return ffha_pkg::ST_DOUBLE;
    chunk_free[blk] = 1'b1;
    avail_total += chunk_size[blk] + ffha_pkg::HEADER_BYTES;
    if (avail_total > ffha_pkg::ARENA_BYTES) avail_total = ffha_pkg::ARENA_BYTES;
    cur = free_head_off;
    valid = free_list_valid;
    while (valid && cur < ffha_pkg::ARENA_BYTES && cur < blk) begin
      prev = cur;
      has_prev = 1'b1;
      valid = chunk_has_next[cur];
      cur = chunk_next[cur];
    end
    if (valid && cur >= ffha_pkg::ARENA_BYTES) valid = 1'b0;
    if (has_prev && prev + ffha_pkg::HEADER_BYTES + chunk_size[prev] == blk) begin
      chunk_size[prev] += ffha_pkg::HEADER_BYTES + chunk_size[blk];
      blk = prev;
    end else begin
      set_link(has_prev, prev, 1'b1, blk);
      chunk_next[blk] = cur;
      chunk_has_next[blk] = valid;
    end
    if (valid && blk + ffha_pkg::HEADER_BYTES + chunk_size[blk] == cur) begin
      chunk_size[blk] += ffha_pkg::HEADER_BYTES + chunk_size[cur];
      chunk_next[blk] = chunk_next[cur];
      chunk_has_next[blk] = chunk_has_next[cur];
    end
    return ffha_pkg::ST_OK;
  endfunction

  // drive one request, hold until transfer, then queue the expected response
  task automatic send_req(logic kind, int req_size, int addr,
                          output ffha_pkg::out_rsp_t rsp);
    ffha_pkg::in_req_t req;
    int got_addr;
    req.req_type = kind;
    req.alloc_size = req_size[15:0];
    req.block_address = addr[11:0];
    start <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    got_addr = 0;
    if (kind == ffha_pkg::REQ_ALLOC) rsp.status = heap_allocate(int'(req.alloc_size), got_addr);
    else rsp.status = heap_release(int'(req.block_address));
    rsp.result_address = got_addr[11:0];
    rsp.avail_bytes = avail_total[12:0];
    pending_rsp.push_back(rsp);
    if (kind == ffha_pkg::REQ_ALLOC && rsp.status == ffha_pkg::ST_OK)
      live_blocks.push_back(got_addr);
  endtask

  task automatic alloc_req(int req_size, output int addr);
    ffha_pkg::out_rsp_t rsp;
    send_req(ffha_pkg::REQ_ALLOC, req_size, 0, rsp);
    addr = int'(rsp.result_address);
  endtask

  task automatic free_req(int addr);
    ffha_pkg::out_rsp_t rsp;
    send_req(ffha_pkg::REQ_FREE, 0, addr, rsp);
    if (rsp.status == ffha_pkg::ST_OK) begin
      foreach (live_blocks[i]) begin
        if (live_blocks[i] == addr) begin
          live_blocks.delete(i);
          break;
        end
      end
      released_blocks.push_back(addr);
    end
  endtask

  // sender bursts: random length, random gap, some back-to-back stretches
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 10);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // size and null corner cases, exact fits and merges on both sides
  task automatic test_directed();
    int a;
    int b;
    int c;
    int d;
    alloc_req(0, a);
    alloc_req(65535, a);
    free_req(0);
    free_req(8);
    free_req(4095);
    alloc_req(1, a);
    free_req(a + 4);
    free_req(a);
    free_req(a);
    alloc_req(32, a);
    alloc_req(32, b);
    alloc_req(25, c);
    alloc_req(32, d);
    free_req(b);
    free_req(d);
    free_req(c);
    free_req(a);
    alloc_req(4080, a);
    alloc_req(8, b);
    free_req(a);
    alloc_req(4064, a);
    alloc_req(4096, b);
    free_req(a);
  endtask

  // mostly legal alloc/free traffic, with some noise and double frees
  task automatic test_random();
    int pick;
    int sz;
    int addr;
    int idx;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pace();
      pick = $urandom_range(0, 99);
      if (pick < 45 || (pick < 85 && live_blocks.size() == 0)) begin
        case ($urandom_range(0, 9))
          0: sz = $urandom_range(0, 65535);
          1: sz = $urandom_range(512, 4096);
          default: sz = $urandom_range(1, 200);
        endcase
        alloc_req(sz, addr);
      end else if (pick < 85) begin
        idx = $urandom_range(0, live_blocks.size() - 1);
        free_req(live_blocks[idx]);
      end else if (pick < 92 && released_blocks.size() > 0) begin
        free_req(released_blocks[$urandom_range(0, released_blocks.size() - 1)]);
      end else if (pick < 96) begin
        free_req($urandom_range(0, 4095));
      end else begin
        alloc_req(0, addr);
      end
    end
    start <= 1'b0;
  endtask

  // response checker
  always @(posedge clk) begin
    ffha_pkg::out_rsp_t exp_rsp;
    if (rst_n && out_valid) begin
      if (pending_rsp.size() == 0) begin
        $error("response with nothing outstanding: %p", out_data);
        error_count++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (out_data.status !== exp_rsp.status) begin
          $error("status exp %0d got %0d", exp_rsp.status, out_data.status);
          error_count++;
        end
        if (out_data.result_address !== exp_rsp.result_address) begin
          $error("result_address exp %0d got %0d", exp_rsp.result_address,
                 out_data.result_address);
          error_count++;
        end
        if (out_data.avail_bytes !== exp_rsp.avail_bytes) begin
          $error("avail_bytes exp %0d got %0d", exp_rsp.avail_bytes, out_data.avail_bytes);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    error_count = 0;
    cycle_count = 0;
    burst_left = 0;
    heap_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
